/* sv/drpc_pkg.sv */
// shared types, register codes and reset values for the descent rate pid controller
package drpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KI       = 3'd2,
    CFG_KD       = 3'd3,
    CFG_IZONE    = 3'd4,
    CFG_LIMIT    = 3'd5,
    CFG_THROTTLE = 3'd6,
    CFG_PERIOD   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] velocity_setpoint;
    logic [19:0] proportional_gain;
    logic [19:0] integral_gain;
    logic [19:0] derivative_gain;
    logic [14:0] integral_zone;
    logic [14:0] output_limit;
    logic [15:0] base_throttle;
    logic [15:0] update_period_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    velocity_setpoint: 16'hFE00,
    proportional_gain: 20'd39322,
    integral_gain:     20'd33,
    derivative_gain:   20'd8192,
    integral_zone:     15'd154,
    output_limit:      15'd2560,
    base_throttle:     16'd42240,
    update_period_ms:  16'd40
  };

  typedef struct packed {
    logic [31:0] last_update_time;
    logic [16:0] prior_error;
    logic [47:0] integral_sum;
    logic [15:0] held_pwm;
    logic [15:0] held_term;
  } state_t;

  typedef struct packed {
    logic [15:0] pwm_value;
    logic        updated;
    logic [15:0] control_term;
  } result_t;

endpackage

/* sv/drpc_sample_if.sv */
// input channel carrying one velocity sample and its time stamp
interface drpc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_velocity;
  logic        [31:0] time_ms;

  modport source (output valid, output measured_velocity, output time_ms, input ready);
  modport sink   (input valid, input measured_velocity, input time_ms, output ready);
endinterface

/* sv/drpc_result_if.sv */
// output channel carrying one controller result
interface drpc_result_if;
  logic               valid;
  logic               ready;
  logic        [15:0] pwm_value;
  logic               updated;
  logic signed [15:0] control_term;

  modport source (output valid, output pwm_value, output updated, output control_term,
                  input ready);
  modport sink   (input valid, input pwm_value, input updated, input control_term,
                  output ready);
endinterface

/* sv/drpc_pid_math.sv */
// pid datapath: error, integral zone, saturating integrator, clamp, rounding, drive
module drpc_pid_math (
  input  drpc_pkg::cfg_t    cfg_i,
  input  drpc_pkg::state_t  state_i,
  input  logic [15:0]       measured_velocity_i,
  input  logic [31:0]       time_ms_i,
  output drpc_pkg::state_t  state_o,
  output drpc_pkg::result_t result_o
);

  logic signed [16:0] err;
  logic        [16:0] err_mag;
  logic        [31:0] elapsed;
  logic               upd;
  logic               in_zone;
  logic signed [37:0] ki_prod;
  logic signed [37:0] kp_prod;
  logic signed [17:0] err_diff;
  logic signed [38:0] kd_prod;
  logic signed [48:0] integ_sum;
  logic        [47:0] integ_sat;
  logic        [47:0] integ_new;
  logic signed [49:0] total;
  logic signed [49:0] lim;
  logic signed [49:0] clamped;
  logic signed [49:0] rounded;
  logic signed [15:0] term;
  logic signed [17:0] drive;
  logic        [15:0] drive_sat;

  assign err = $signed({cfg_i.velocity_setpoint[15], cfg_i.velocity_setpoint})
             - $signed({measured_velocity_i[15], measured_velocity_i});
  assign err_mag = err[16] ? 17'(-err) : 17'(err);

  // wrap-safe elapsed time
  assign elapsed = time_ms_i - state_i.last_update_time;
  assign upd     = elapsed > {16'd0, cfg_i.update_period_ms};
  assign in_zone = err_mag < {2'd0, cfg_i.integral_zone};

  assign ki_prod = $signed({1'b0, cfg_i.integral_gain}) * err;
  assign kp_prod = $signed({1'b0, cfg_i.proportional_gain}) * err;
  assign err_diff = $signed({err[16], err})
                  - $signed({state_i.prior_error[16], state_i.prior_error});
  assign kd_prod = $signed({1'b0, cfg_i.derivative_gain}) * err_diff;

  assign integ_sum = $signed({state_i.integral_sum[47], state_i.integral_sum})
                   + $signed({{11{ki_prod[37]}}, ki_prod});

  always_comb begin
    if (integ_sum[48] != integ_sum[47]) begin
      integ_sat = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      integ_sat = integ_sum[47:0];
    end
  end

  assign integ_new = (upd && in_zone) ? integ_sat : state_i.integral_sum;

  assign total = $signed({{12{kp_prod[37]}}, kp_prod})
               + $signed({{2{integ_new[47]}}, integ_new})
               + $signed({{11{kd_prod[38]}}, kd_prod});

  assign lim = $signed({19'd0, cfg_i.output_limit, 16'd0});

  always_comb begin
    if (total > lim) begin
      clamped = lim;
    end else if (total < -lim) begin
      clamped = -lim;
    end else begin
      clamped = total;
    end
  end

  // round half up to q8.8: arithmetic shift is the floor
  assign rounded = clamped + 50'sd32768;
  assign term    = rounded[31:16];

  assign drive = $signed({2'd0, cfg_i.base_throttle}) + $signed({{2{term[15]}}, term});

  always_comb begin
    if (drive[17]) begin
      drive_sat = 16'd0;
    end else if (drive[16]) begin
      drive_sat = 16'hFFFF;
    end else begin
      drive_sat = drive[15:0];
    end
  end

  always_comb begin
    state_o.last_update_time = upd ? time_ms_i : state_i.last_update_time;
    state_o.prior_error      = err;
    state_o.integral_sum     = integ_new;
    state_o.held_pwm         = upd ? drive_sat : state_i.held_pwm;
    state_o.held_term        = upd ? term : state_i.held_term;
  end

  assign result_o.pwm_value    = state_o.held_pwm;
  assign result_o.updated      = upd;
  assign result_o.control_term = state_o.held_term;

endmodule

/* sv/descent_rate_pid_controller_core.sv */
// descent rate pid controller: input register, pid datapath and result register
// path: a sample is held in the input register, then passes the pid datapath into the result register
// throughput: one sample per cycle while the result is taken; controller state is written as the result is registered
// while the result is not taken the result register holds, and a full input register holds with it
// reset: configuration returns to its defaults, controller state and valid flags clear
module descent_rate_pid_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  drpc_sample_if.sink                        in_if,
  drpc_result_if.source                      out_if,
  input  logic                               cfg_we_i,
  input  logic [drpc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [drpc_pkg::CfgDataW-1:0]      cfg_data_i
);

  drpc_pkg::cfg_t    cfg_q, cfg_d;
  drpc_pkg::state_t  state_q, state_next;
  drpc_pkg::result_t res_q, res_next;

  logic        in_valid_q;
  logic [15:0] vel_q;
  logic [31:0] time_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;

  // result register frees when empty or taken
  assign advance      = !out_valid_q || out_if.ready;
  assign fire         = in_valid_q && advance;
  assign in_if.ready  = !in_valid_q || advance;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (drpc_pkg::cfg_idx_e'(cfg_idx_i))
        drpc_pkg::CFG_SETPOINT: cfg_d.velocity_setpoint = cfg_data_i[15:0];
        drpc_pkg::CFG_KP:       cfg_d.proportional_gain = cfg_data_i;
        drpc_pkg::CFG_KI:       cfg_d.integral_gain     = cfg_data_i;
        drpc_pkg::CFG_KD:       cfg_d.derivative_gain   = cfg_data_i;
        drpc_pkg::CFG_IZONE:    cfg_d.integral_zone     = cfg_data_i[14:0];
        drpc_pkg::CFG_LIMIT:    cfg_d.output_limit      = cfg_data_i[14:0];
        drpc_pkg::CFG_THROTTLE: cfg_d.base_throttle     = cfg_data_i[15:0];
        drpc_pkg::CFG_PERIOD:   cfg_d.update_period_ms  = cfg_data_i[15:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= drpc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  drpc_pid_math u_math (
    .cfg_i               (cfg_q),
    .state_i             (state_q),
    .measured_velocity_i (vel_q),
    .time_ms_i           (time_q),
    .state_o             (state_next),
    .result_o            (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      vel_q  <= in_if.measured_velocity;
      time_q <= in_if.time_ms;
    end
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.pwm_value    = res_q.pwm_value;
  assign out_if.updated      = res_q.updated;
  assign out_if.control_term = res_q.control_term;

endmodule

/* test/testbench.sv */
// self-checking testbench for the descent rate pid controller core
module testbench;
  import drpc_pkg::*;

  localparam int unsigned CycleLimit = 40000;
  localparam int unsigned MaxPrinted = 40;
  localparam longint IntegMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint IntegMin = -IntegMax - 1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  drpc_sample_if sample_ch ();
  drpc_result_if result_ch ();

  descent_rate_pid_controller_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (sample_ch),
    .out_if     (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // controller mirror: configuration and state
  cfg_t               ctl_cfg = CfgReset;
  logic        [31:0] last_upd_time = '0;
  int                 prior_err = 0;
  longint             integ_acc = 0;
  logic        [15:0] held_pwm = '0;
  logic signed [15:0] held_term = '0;

  result_t     pending_drive_q[$];
  logic [31:0] t_now = '0;
  int unsigned stall_pct = 23;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    if (errors < MaxPrinted) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic result_t predict_drive(input logic signed [15:0] vel,
                                            input logic [31:0] now);
    longint  err;
    longint  mag;
    longint  lim;
    longint  acc;
    longint  sum;
    longint  term;
    longint  pwm;
    result_t r;
    err = longint'($signed(ctl_cfg.velocity_setpoint)) - longint'(vel);
    r.updated = (now - last_upd_time) > 32'(ctl_cfg.update_period_ms);
    if (r.updated) begin
      mag = (err < 0) ? -err : err;
      lim = longint'(ctl_cfg.output_limit) * 65536;
      last_upd_time = now;
      if (mag < longint'(ctl_cfg.integral_zone)) begin
        acc = integ_acc + longint'(ctl_cfg.integral_gain) * err;
        if (acc > IntegMax) acc = IntegMax;
        if (acc < IntegMin) acc = IntegMin;
        integ_acc = acc;
      end
      sum = longint'(ctl_cfg.proportional_gain) * err + integ_acc
          + longint'(ctl_cfg.derivative_gain) * (err - longint'(prior_err));
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      // round half up from 24 to 8 fraction bits
      term = (sum + 32768) >>> 16;
      pwm = longint'(ctl_cfg.base_throttle) + term;
      if (pwm < 0) pwm = 0;
      if (pwm > 65535) pwm = 65535;
      held_term = 16'(term);
      held_pwm = 16'(pwm);
    end
    prior_err = int'(err);
    r.pwm_value = held_pwm;
    r.control_term = held_term;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_drive_q.size() == 0) begin
        report_mismatch("result transfer with no sample outstanding");
      end else begin
        want = pending_drive_q.pop_front();
        if (result_ch.pwm_value !== want.pwm_value)
          report_mismatch($sformatf("pwm_value got %0d want %0d",
                                    result_ch.pwm_value, want.pwm_value));
        if (result_ch.updated !== want.updated)
          report_mismatch($sformatf("updated got %0b want %0b",
                                    result_ch.updated, want.updated));
        if (result_ch.control_term !== want.control_term)
          report_mismatch($sformatf("control_term got %0d want %0d",
                                    result_ch.control_term, $signed(want.control_term)));
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] vel, input logic [31:0] now);
    while ($urandom_range(99) < stall_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.measured_velocity <= vel;
    sample_ch.time_ms <= now;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    t_now = now;
    pending_drive_q.push_back(predict_drive(vel, now));
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
    // let the pipeline settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_SETPOINT: ctl_cfg.velocity_setpoint = data[15:0];
      CFG_KP:       ctl_cfg.proportional_gain = data;
      CFG_KI:       ctl_cfg.integral_gain = data;
      CFG_KD:       ctl_cfg.derivative_gain = data;
      CFG_IZONE:    ctl_cfg.integral_zone = data[14:0];
      CFG_LIMIT:    ctl_cfg.output_limit = data[14:0];
      CFG_THROTTLE: ctl_cfg.base_throttle = data[15:0];
      CFG_PERIOD:   ctl_cfg.update_period_ms = data[15:0];
      default:      ;
    endcase
  endtask

  // unused upper data bits carry junk, the register must drop them
  task automatic load_config(input cfg_t c);
    wait_idle();
    write_reg(CFG_SETPOINT, {4'($urandom), c.velocity_setpoint});
    write_reg(CFG_KP,       c.proportional_gain);
    write_reg(CFG_KI,       c.integral_gain);
    write_reg(CFG_KD,       c.derivative_gain);
    write_reg(CFG_IZONE,    {5'($urandom), c.integral_zone});
    write_reg(CFG_LIMIT,    {5'($urandom), c.output_limit});
    write_reg(CFG_THROTTLE, {4'($urandom), c.base_throttle});
    write_reg(CFG_PERIOD,   {4'($urandom), c.update_period_ms});
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.velocity_setpoint = ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(2047)) - 16'd1024;
    c.proportional_gain = ($urandom_range(3) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(131071));
    c.integral_gain     = ($urandom_range(3) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(4095));
    c.derivative_gain   = ($urandom_range(3) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(65535));
    c.integral_zone     = ($urandom_range(3) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(1024));
    c.output_limit      = ($urandom_range(3) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(8192, 512));
    c.base_throttle     = 16'($urandom);
    c.update_period_ms  = ($urandom_range(4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(12));
    return c;
  endfunction

  task automatic run_samples(input int count);
    int                 e;
    int                 span;
    int unsigned        pick;
    logic signed [15:0] vel;
    logic        [31:0] stamp;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      span = int'(ctl_cfg.integral_zone) + 4;
      if (span > 2048) span = 2048;
      if (pick < 25) begin
        // errors right at the integral zone edge
        e = int'(ctl_cfg.integral_zone) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) e = -e;
      end else begin
        e = int'($urandom_range(2 * span)) - span;
      end
      vel = (pick < 70) ? 16'(int'($signed(ctl_cfg.velocity_setpoint)) - e) : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 85)
        stamp = t_now + $urandom_range(2 * int'(ctl_cfg.update_period_ms) + 2);
      else if (pick < 95)
        stamp = t_now + 32'(ctl_cfg.update_period_ms) + $urandom_range(1);
      else
        stamp = $urandom;
      send_sample(vel, stamp);
    end
  endtask

  task automatic test_first_update();
    send_sample(16'sd0, 32'd0);
    send_sample(16'sd0, 32'd40);
    send_sample(16'sd0, 32'd41);
  endtask

  task automatic test_velocity_extremes();
    send_sample(-16'sd32768, 32'd100);
    send_sample(16'sd32767, 32'd200);
    // no update here, but the prior error is still written
    send_sample(16'sd32767, 32'd210);
    send_sample(-16'sd32768, 32'd300);
  endtask

  task automatic test_integral_zone();
    send_sample(-16'sd665, 32'd400);
    send_sample(-16'sd359, 32'd500);
    send_sample(-16'sd666, 32'd600);
    send_sample(-16'sd358, 32'd700);
    send_sample(-16'sd512, 32'd800);
  endtask

  task automatic test_time_wrap();
    send_sample(-16'sd600, 32'hFFFF_FFF0);
    send_sample(-16'sd600, 32'h0000_0018);
    send_sample(-16'sd600, 32'h0000_0019);
  endtask

  task automatic test_clamp_and_saturation();
    cfg_t c;
    c = CfgReset;
    c.output_limit = '0;
    c.integral_zone = '0;
    load_config(c);
    send_sample(16'sd1000, t_now + 41);
    c = '1;
    c.velocity_setpoint = 16'h8000;
    c.base_throttle = '0;
    c.update_period_ms = '0;
    load_config(c);
    send_sample(16'sd32767, t_now + 1);
    c.velocity_setpoint = 16'h7FFF;
    c.base_throttle = '1;
    load_config(c);
    send_sample(-16'sd32768, t_now + 1);
    // period zero: any time step fires, an equal stamp does not
    send_sample(-16'sd32768, t_now);
    send_sample(16'sd0, t_now + 1);
    c.update_period_ms = '1;
    load_config(c);
    send_sample(16'sd0, t_now + 32'd65535);
    send_sample(16'sd0, t_now + 32'd65536);
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          c = '1;
          c.velocity_setpoint = 16'h7FFF;
        end
        1: begin
          c = '0;
          c.velocity_setpoint = 16'h8000;
        end
        2: c = CfgReset;
        default: c = random_config();
      endcase
      stall_pct = (p == 3) ? 0 : 23;
      load_config(c);
      run_samples(150);
    end
    stall_pct = 23;
  endtask

  // push the integrator hard both ways with the largest in-zone error
  task automatic test_integrator_windup();
    cfg_t c;
    c = '0;
    c.velocity_setpoint = 16'h7FFF;
    c.integral_gain = '1;
    c.integral_zone = '1;
    c.output_limit = '1;
    stall_pct = 0;
    load_config(c);
    repeat (20) send_sample(16'sd1, t_now + 1);
    c.velocity_setpoint = 16'h8000;
    load_config(c);
    repeat (20) send_sample(-16'sd2, t_now + 1);
    stall_pct = 23;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SETPOINT;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.measured_velocity = '0;
    sample_ch.time_ms = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_update();
    test_velocity_extremes();
    test_integral_zone();
    test_time_wrap();
    test_clamp_and_saturation();
    test_random_phases();
    test_integrator_windup();
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
